[sv/psl_pkg.sv]
`timescale 1ns / 1ps

package psl_pkg;

  // table size and derived widths
  localparam int NUM_SLOTS = 16;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
  localparam int SLOT_W    = 4;
  localparam int FRAG_W    = 16;
  localparam int ID_W      = 32;

  // operation codes
  localparam logic [2:0] OP_LOOKUP   = 3'd0;
  localparam logic [2:0] OP_ADD      = 3'd1;
  localparam logic [2:0] OP_REMOVE   = 3'd2;
  localparam logic [2:0] OP_DORMANT  = 3'd3;
  localparam logic [2:0] OP_RESUME   = 3'd4;
  localparam logic [2:0] OP_SET_FRAG = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_PRESENT   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // configuration register indexes and reset values
  localparam logic [1:0] CFG_FRAG_DEFAULT = 2'd0;
  localparam logic [1:0] CFG_FRAG_MIN     = 2'd1;
  localparam logic [1:0] CFG_FRAG_MAX     = 2'd2;

  localparam logic [FRAG_W-1:0] FRAG_DEFAULT_RST = 16'd1200;
  localparam logic [FRAG_W-1:0] FRAG_MIN_RST     = 16'd512;
  localparam logic [FRAG_W-1:0] FRAG_MAX_RST     = 16'd1472;

  typedef struct packed {
    logic [2:0]        op;
    logic [ID_W-1:0]   peer_id;
    logic              is_local;
    logic [FRAG_W-1:0] frag_request;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic              slot_local;
    logic              slot_dormant;
    logic [FRAG_W-1:0] slot_frag;
  } rsp_t;

  typedef struct packed {
    logic [FRAG_W-1:0] frag_default;
    logic [FRAG_W-1:0] frag_min;
    logic [FRAG_W-1:0] frag_max;
  } cfg_t;

  typedef struct packed {
    logic              used;
    logic [ID_W-1:0]   peer;
    logic              is_local;
    logic              asleep;
    logic [FRAG_W-1:0] frag;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    entry_t           data;
  } tbl_wr_t;

  // slot number as carried in a result: low bits of the index
  function automatic logic [SLOT_W-1:0] slot_field(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SLOT_W-1:0] t;
    t = {{SLOT_W{1'b0}}, idx};
    return t[SLOT_W-1:0];
  endfunction

endpackage

[sv/psl_table.sv]
`timescale 1ns / 1ps

module psl_table (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [psl_pkg::IDX_W-1:0] rd_idx,
  output psl_pkg::entry_t          rd_entry,
  input  psl_pkg::tbl_wr_t         wr
);
  import psl_pkg::*;

  logic [NUM_SLOTS-1:0] used;
  logic [ID_W-1:0]      peer     [NUM_SLOTS];
  logic                 is_local [NUM_SLOTS];
  logic                 asleep   [NUM_SLOTS];
  logic [FRAG_W-1:0]    frag     [NUM_SLOTS];

  // in-use flags are the only part that needs clearing
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (wr.en) begin
      used[wr.idx] <= wr.data.used;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      peer[wr.idx]     <= wr.data.peer;
      is_local[wr.idx] <= wr.data.is_local;
      asleep[wr.idx]   <= wr.data.asleep;
      frag[wr.idx]     <= wr.data.frag;
    end
  end

  always_comb begin
    rd_entry.used     = used[rd_idx];
    rd_entry.peer     = peer[rd_idx];
    rd_entry.is_local = is_local[rd_idx];
    rd_entry.asleep   = asleep[rd_idx];
    rd_entry.frag     = frag[rd_idx];
  end

endmodule

[sv/psl_ctrl.sv]
`timescale 1ns / 1ps

module psl_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  psl_pkg::cfg_t             cfg,
  input  logic                      start,
  input  psl_pkg::req_t             req,
  input  logic                      out_free,
  output logic                      idle,
  output logic                      done,
  output psl_pkg::rsp_t             rsp,
  output logic [psl_pkg::IDX_W-1:0] rd_idx,
  input  psl_pkg::entry_t           rd_entry,
  output psl_pkg::tbl_wr_t          wr
);
  import psl_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_SLOTS - 1);

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] cnt;
  req_t             cur;
  logic             found;
  logic [IDX_W-1:0] hit_idx;
  logic             have_free;
  logic [IDX_W-1:0] free_idx;

  logic             hit;
  logic             alloc;
  logic [IDX_W-1:0] target;
  entry_t           upd;
  logic [FRAG_W-1:0] clamped;

  // zero means default, then lower bound, then upper bound
  function automatic logic [FRAG_W-1:0] clamp_frag(input logic [FRAG_W-1:0] r,
                                                   input cfg_t c);
    logic [FRAG_W-1:0] f;
    f = (r != '0) ? r : c.frag_default;
    if (f < c.frag_min) f = c.frag_min;
    if (f > c.frag_max) f = c.frag_max;
    return f;
  endfunction

  assign idle    = (state == S_IDLE);
  assign hit     = rd_entry.used && (rd_entry.peer == cur.peer_id);
  assign alloc   = (cur.op == OP_ADD) && !found;
  assign target  = alloc ? free_idx : hit_idx;
  assign rd_idx  = (state == S_EXEC) ? target : cnt[IDX_W-1:0];
  assign clamped = clamp_frag(cur.frag_request, cfg);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start) state_next = S_SCAN;
      S_SCAN: if (cnt == LAST) state_next = S_EXEC;
      S_EXEC: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // one compare per cycle: match on id, and remember the lowest free slot
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cur       <= req;
      cnt       <= '0;
      found     <= 1'b0;
      have_free <= 1'b0;
      hit_idx   <= '0;
      free_idx  <= '0;
    end else if (state == S_SCAN) begin
      cnt <= cnt + 1'b1;
      if (hit && !found) begin
        found   <= 1'b1;
        hit_idx <= cnt[IDX_W-1:0];
      end
      if (!rd_entry.used && !have_free) begin
        have_free <= 1'b1;
        free_idx  <= cnt[IDX_W-1:0];
      end
    end
  end

  // result and write-back in the execute cycle
  always_comb begin
    upd        = rd_entry;
    wr.en      = 1'b0;
    wr.idx     = target;
    rsp.status = ST_OK;
    if (cur.op == OP_ADD) begin
      if (found) begin
        rsp.status = ST_PRESENT;
      end else if (!have_free) begin
        rsp.status = ST_FULL;
      end else begin
        upd.used     = 1'b1;
        upd.peer     = cur.peer_id;
        upd.is_local = cur.is_local;
        upd.asleep   = 1'b0;
        upd.frag     = clamped;
        wr.en        = 1'b1;
      end
    end else if (!found) begin
      rsp.status = ST_NOT_FOUND;
    end else begin
      case (cur.op)
        OP_REMOVE: begin
          upd.used   = 1'b0;
          upd.asleep = 1'b0;
          wr.en      = 1'b1;
        end
        OP_DORMANT: begin
          upd.asleep = 1'b1;
          wr.en      = 1'b1;
        end
        OP_RESUME: begin
          upd.asleep = 1'b0;
          wr.en      = 1'b1;
        end
        OP_SET_FRAG: begin
          upd.frag = clamped;
          wr.en    = 1'b1;
        end
        default: wr.en = 1'b0;
      endcase
    end
    wr.data = upd;
    if (state != S_EXEC || !out_free) wr.en = 1'b0;

    if (rsp.status == ST_FULL || rsp.status == ST_NOT_FOUND) begin
      rsp.slot         = '0;
      rsp.slot_local   = 1'b0;
      rsp.slot_dormant = 1'b0;
      rsp.slot_frag    = '0;
    end else begin
      rsp.slot         = slot_field(target);
      rsp.slot_local   = upd.is_local;
      rsp.slot_dormant = upd.asleep;
      rsp.slot_frag    = upd.frag;
    end
  end

  assign done = (state == S_EXEC) && out_free;

endmodule

[sv/peer_slot_table.sv]
`timescale 1ns / 1ps

// peer slot table: sixteen slots keyed by a 32-bit peer id. each request is
// one operation (lookup, add, remove, dormant, resume, set fragment size) and
// yields exactly one response with a status, the slot concerned and that
// slot's flags and fragment size after the operation. a request is handled by
// a single id comparator that walks the slots one per cycle, followed by an
// execute state that updates the slot and loads the response register, so a
// new request is accepted only after the previous one has left the execute
// state. req_stall is high while a request is being worked on, and also holds
// the execute state while the previous response still sits unaccepted in the
// output register.
// configuration registers (frag_default, frag_min, frag_max) are written
// through cfg_we/cfg_index/cfg_data and should only change while idle.

module peer_slot_table (
  input  logic                       clk,
  input  logic                       rst,
  // request channel
  input  logic                       req_valid,
  output logic                       req_stall,
  input  psl_pkg::req_t              req_data,
  // response channel
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output psl_pkg::rsp_t              rsp_data,
  // configuration writes
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [psl_pkg::FRAG_W-1:0] cfg_data
);
  import psl_pkg::*;

  cfg_t             cfg;
  logic             idle;
  logic             done;
  logic             out_free;
  rsp_t             rsp_next;
  logic [IDX_W-1:0] rd_idx;
  entry_t           rd_entry;
  tbl_wr_t          wr;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frag_default <= FRAG_DEFAULT_RST;
      cfg.frag_min     <= FRAG_MIN_RST;
      cfg.frag_max     <= FRAG_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAG_DEFAULT: cfg.frag_default <= cfg_data;
        CFG_FRAG_MIN:     cfg.frag_min     <= cfg_data;
        CFG_FRAG_MAX:     cfg.frag_max     <= cfg_data;
        default: ;
      endcase
    end
  end

  // a new request only when the sequencer is idle
  assign req_stall = !idle;

  // output register frees when empty or being taken this cycle
  assign out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) rsp_data <= rsp_next;
  end

  psl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .start    (req_valid),
    .req      (req_data),
    .out_free (out_free),
    .idle     (idle),
    .done     (done),
    .rsp      (rsp_next),
    .rd_idx   (rd_idx),
    .rd_entry (rd_entry),
    .wr       (wr)
  );

  psl_table u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_idx   (rd_idx),
    .rd_entry (rd_entry),
    .wr       (wr)
  );

endmodule

[dv/psl_checker.sv]
`timescale 1ns / 1ps

// watches both channels and the config port, keeps its own copy of the
// slot table and compares every response with the oldest prediction
module psl_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  input  logic                       req_stall,
  input  psl_pkg::req_t              req_data,
  input  logic                       rsp_valid,
  input  logic                       rsp_stall,
  input  psl_pkg::rsp_t              rsp_data,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [psl_pkg::FRAG_W-1:0] cfg_data,
  output int                         fail_count,
  output int                         pending_count,
  output int                         rsp_count,
  output int                         full_count,
  output int                         dup_count
);
  import psl_pkg::*;

  logic [FRAG_W-1:0] cfg_def, cfg_lo, cfg_hi;

  logic              tab_used  [NUM_SLOTS];
  logic [ID_W-1:0]   tab_id    [NUM_SLOTS];
  logic              tab_local [NUM_SLOTS];
  logic              tab_sleep [NUM_SLOTS];
  logic [FRAG_W-1:0] tab_frag  [NUM_SLOTS];

  rsp_t outstanding_rsp[$];
  rsp_t predicted, oldest;
  int   n_fail = 0;

  assign fail_count = n_fail;

  initial begin
    pending_count = 0;
    rsp_count     = 0;
    full_count    = 0;
    dup_count     = 0;
  end

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (n_fail < 40)
      $display("%0t ns mismatch on %s: got %0h, want %0h", $time, what, got, want);
    n_fail++;
  endtask

  function automatic logic [FRAG_W-1:0] bound_frag(input logic [FRAG_W-1:0] asked);
    logic [FRAG_W-1:0] f;
    f = (asked != '0) ? asked : cfg_def;
    if (f < cfg_lo) f = cfg_lo;
    if (f > cfg_hi) f = cfg_hi;
    return f;
  endfunction

  function automatic rsp_t slot_view(input logic [1:0] st, input int idx);
    rsp_t o;
    o              = '0;
    o.status       = st;
    o.slot         = idx[SLOT_W-1:0];
    o.slot_local   = tab_local[idx];
    o.slot_dormant = tab_sleep[idx];
    o.slot_frag    = tab_frag[idx];
    return o;
  endfunction

  // one table operation: updates the local table and returns the response
  task automatic apply_request(input req_t r, output rsp_t o);
    int hit, free_at;
    hit     = -1;
    free_at = -1;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (hit < 0 && tab_used[i] && tab_id[i] == r.peer_id) hit = i;
      if (free_at < 0 && !tab_used[i]) free_at = i;
    end
    o = '0;
    if (r.op == OP_ADD) begin
      if (hit >= 0) begin
        o = slot_view(ST_PRESENT, hit);
      end else if (free_at < 0) begin
        o.status = ST_FULL;
      end else begin
        tab_used[free_at]  = 1'b1;
        tab_id[free_at]    = r.peer_id;
        tab_local[free_at] = r.is_local;
        tab_sleep[free_at] = 1'b0;
        tab_frag[free_at]  = bound_frag(r.frag_request);
        o = slot_view(ST_OK, free_at);
      end
    end else if (hit < 0) begin
      o.status = ST_NOT_FOUND;
    end else begin
      case (r.op)
        OP_REMOVE: begin
          tab_used[hit]  = 1'b0;
          tab_sleep[hit] = 1'b0;
        end
        OP_DORMANT:  tab_sleep[hit] = 1'b1;
        OP_RESUME:   tab_sleep[hit] = 1'b0;
        OP_SET_FRAG: tab_frag[hit]  = bound_frag(r.frag_request);
        default: ;
      endcase
      o = slot_view(ST_OK, hit);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg_def = FRAG_DEFAULT_RST;
      cfg_lo  = FRAG_MIN_RST;
      cfg_hi  = FRAG_MAX_RST;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        tab_used[i]  = 1'b0;
        tab_id[i]    = '0;
        tab_local[i] = 1'b0;
        tab_sleep[i] = 1'b0;
        tab_frag[i]  = FRAG_DEFAULT_RST;
      end
      outstanding_rsp.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAG_DEFAULT: cfg_def = cfg_data;
          CFG_FRAG_MIN:     cfg_lo  = cfg_data;
          CFG_FRAG_MAX:     cfg_hi  = cfg_data;
          default: ;
        endcase
      end
      if (req_valid && !req_stall) begin
        apply_request(req_data, predicted);
        outstanding_rsp.push_back(predicted);
      end
      if (rsp_valid && !rsp_stall) begin
        rsp_count <= rsp_count + 1;
        if (outstanding_rsp.size() == 0) begin
          note_mismatch("response with nothing outstanding", 32'(rsp_data), '0);
        end else begin
          oldest = outstanding_rsp.pop_front();
          if (oldest.status == ST_FULL)    full_count <= full_count + 1;
          if (oldest.status == ST_PRESENT) dup_count  <= dup_count + 1;
          if (rsp_data.status !== oldest.status)
            note_mismatch("status", 32'(rsp_data.status), 32'(oldest.status));
          if (rsp_data.slot !== oldest.slot)
            note_mismatch("slot", 32'(rsp_data.slot), 32'(oldest.slot));
          if (rsp_data.slot_local !== oldest.slot_local)
            note_mismatch("slot_local", 32'(rsp_data.slot_local),
                          32'(oldest.slot_local));
          if (rsp_data.slot_dormant !== oldest.slot_dormant)
            note_mismatch("slot_dormant", 32'(rsp_data.slot_dormant),
                          32'(oldest.slot_dormant));
          if (rsp_data.slot_frag !== oldest.slot_frag)
            note_mismatch("slot_frag", 32'(rsp_data.slot_frag), 32'(oldest.slot_frag));
        end
      end
    end
    pending_count <= outstanding_rsp.size();
  end

endmodule

[dv/peer_slot_table_tb.sv]
`timescale 1ns / 1ps

// stimulus and verdict for the peer slot table; all prediction and
// comparison lives in psl_checker
module peer_slot_table_tb;
  import psl_pkg::*;

  // op codes the block does not define; they must behave as a lookup
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  localparam int CYCLE_LIMIT     = 600000;
  localparam int SETTLE_CYCLES   = 24;   // longer than one request's walk and execute state
  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 190;
  localparam int POOL_SIZE       = 32;

  typedef enum int {STALL_NONE, STALL_SPARSE, STALL_RUNS, STALL_COMB} stall_mode_t;

  // block inputs, all known from time zero
  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              req_valid = 1'b0;
  req_t              req_data  = '0;
  logic              rsp_stall = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [1:0]        cfg_index = CFG_FRAG_DEFAULT;
  logic [FRAG_W-1:0] cfg_data  = '0;

  logic req_stall;
  logic rsp_valid;
  rsp_t rsp_data;

  int fail_total, pending, rsp_checked, full_seen, dup_seen;

  // receiver pattern state
  stall_mode_t stall_mode   = STALL_NONE;
  int          stall_left   = 0;
  logic        stall_run_on = 1'b0;
  int          cycle_count  = 0;

  // sender state
  logic [ID_W-1:0]   id_pool [POOL_SIZE];
  int                pool_win   = POOL_SIZE;
  int                burst_left = 0;
  logic              gaps_on    = 1'b1;
  int                n_sent     = 0;
  int                n_settings = 1;
  logic [FRAG_W-1:0] cur_lo     = FRAG_MIN_RST;
  logic [FRAG_W-1:0] cur_hi     = FRAG_MAX_RST;

  always #2 clk = ~clk;

  peer_slot_table u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  psl_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req_data      (req_data),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .rsp_data      (rsp_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_total),
    .pending_count (pending),
    .rsp_count     (rsp_checked),
    .full_count    (full_seen),
    .dup_count     (dup_seen)
  );

  // run guard: a hung handshake ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses still outstanding",
               cycle_count, pending);
      $display("tb: failure");
      $finish;
    end
  end

  // response side backpressure, pattern picked per phase
  always @(posedge clk) begin
    case (stall_mode)
      STALL_NONE:   rsp_stall <= 1'b0;
      STALL_SPARSE: rsp_stall <= ($urandom_range(0, 3) == 0);
      STALL_RUNS: begin
        // alternating on/off runs, long enough to back up the block
        if (stall_left == 0) begin
          stall_run_on <= !stall_run_on;
          stall_left   <= $urandom_range(1, 24);
        end else begin
          stall_left <= stall_left - 1;
        end
        rsp_stall <= stall_run_on;
      end
      default: rsp_stall <= ((cycle_count % 7) < 3);
    endcase
  end

  function automatic req_t make_req(input logic [2:0] op, input logic [ID_W-1:0] id,
                                    input logic loc, input logic [FRAG_W-1:0] frag);
    req_t r;
    r.op           = op;
    r.peer_id      = id;
    r.is_local     = loc;
    r.frag_request = frag;
    return r;
  endfunction

  // mostly ids from the pool so adds, removes and updates hit live slots;
  // a few fully random ids land as misses
  function automatic req_t random_req();
    req_t r;
    int   pick;
    pick = $urandom_range(0, 99);
    if (pick < 32)      r.op = OP_ADD;
    else if (pick < 47) r.op = OP_REMOVE;
    else if (pick < 57) r.op = OP_LOOKUP;
    else if (pick < 67) r.op = OP_DORMANT;
    else if (pick < 77) r.op = OP_RESUME;
    else if (pick < 92) r.op = OP_SET_FRAG;
    else if (pick < 96) r.op = OP_SPARE_A;
    else                r.op = OP_SPARE_B;
    if ($urandom_range(0, 9) == 0) r.peer_id = $urandom();
    else                           r.peer_id = id_pool[$urandom_range(0, pool_win - 1)];
    r.is_local = 1'($urandom_range(0, 1));
    // zero means default; also aim at the current bounds and the extremes
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1:    r.frag_request = '0;
      2:       r.frag_request = '1;
      3:       r.frag_request = cur_lo;
      4:       r.frag_request = cur_hi;
      5:       r.frag_request = 16'd1;
      default: r.frag_request = 16'($urandom());
    endcase
    return r;
  endfunction

  // present one request and hold it until taken; between bursts the
  // sender may go quiet for a random gap
  task automatic send_req(input req_t r);
    int gap;
    req_valid <= 1'b1;
    req_data  <= r;
    do @(posedge clk); while (req_stall);
    n_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on) begin
        gap = $urandom_range(0, 30);
        if (gap > 0) begin
          req_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  // hold off until every response is back and the block has gone quiet
  task automatic drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all three fragment registers on consecutive cycles
  task automatic load_frag_cfg(input logic [FRAG_W-1:0] dflt, input logic [FRAG_W-1:0] lo,
                               input logic [FRAG_W-1:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FRAG_DEFAULT;
    cfg_data  <= dflt;
    @(posedge clk);
    cfg_index <= CFG_FRAG_MIN;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= CFG_FRAG_MAX;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_lo = lo;
    cur_hi = hi;
    n_settings++;
  endtask

  initial begin
    logic [FRAG_W-1:0] d, lo, hi;

    // id pool: both extreme ids plus random ones
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = $urandom();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed part at reset settings
    send_req(make_req(OP_ADD, '0, 1'b1, '0));             // zero request takes the default
    send_req(make_req(OP_ADD, '0, 1'b0, 16'd700));        // already present, no change
    send_req(make_req(OP_ADD, '1, 1'b0, 16'd1));          // below min, clamped up
    send_req(make_req(OP_DORMANT, '1, 1'b0, '0));
    send_req(make_req(OP_DORMANT, '1, 1'b1, '0));         // already dormant
    send_req(make_req(OP_RESUME, '1, 1'b0, '0));
    send_req(make_req(OP_RESUME, '1, 1'b1, '0));          // already awake
    send_req(make_req(OP_SET_FRAG, '0, 1'b1, '1));        // above max, clamped down
    send_req(make_req(OP_SPARE_B, '0, 1'b0, '1));         // unused op acts as lookup
    send_req(make_req(OP_REMOVE, '1, 1'b0, '0));          // keeps local flag and size
    send_req(make_req(OP_SET_FRAG, '1, 1'b1, 16'd900));   // gone now, not found
    // fill the table, the last add finds no free slot
    for (int k = 2; k < 18; k++)
      send_req(make_req(OP_ADD, id_pool[k], k[0], 16'($urandom())));

    // random phases, each under its own settings and traffic shape
    for (int p = 0; p < N_PHASES; p++) begin
      if (p > 0) begin
        drain();
        case (p)
          1: load_frag_cfg('0, '0, '1);                     // widest window, zero default
          2: load_frag_cfg('1, '1, '1);                     // everything pinned at the top
          3: load_frag_cfg(16'd1500, 16'd2000, 16'd1000);   // min above max
          4: load_frag_cfg('0, '0, '0);                     // everything pinned at zero
          5: begin
            d  = 16'($urandom());
            lo = 16'($urandom());
            hi = 16'($urandom());
            load_frag_cfg(d, lo, hi);
          end
          6: load_frag_cfg(16'd1, 16'd1, '1);
          default: begin
            lo = 16'($urandom_range(0, 2000));
            hi = lo + 16'($urandom_range(0, 4000));
            d  = 16'($urandom_range(0, 6000));
            load_frag_cfg(d, lo, hi);
          end
        endcase
      end
      stall_mode <= stall_mode_t'(p % 4);
      gaps_on  = (p % 3 != 1);
      pool_win = $urandom_range(6, POOL_SIZE);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_req(random_req());
        // now and then let the pipe run dry mid-phase
        if ($urandom_range(0, 199) == 0) drain();
      end
    end

    drain();

    $display("covered %0d requests across %0d fragment settings, %0d responses compared",
             n_sent, n_settings, rsp_checked);
    $display("of those, %0d hit a full table and %0d found the id already present",
             full_seen, dup_seen);
    if (fail_total == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
